// ===== design/laser_scan_line_decoder_defines.svh =====
// assertion macros used by the decoder's scaler module
`ifndef LASER_SCAN_LINE_DECODER_DEFINES_SVH
`define LASER_SCAN_LINE_DECODER_DEFINES_SVH

// same-cycle implication, off during reset
`define LSLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LSLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lsld_pkg.sv =====
`default_nettype none

package lsld_pkg;

    // result codes
    typedef enum logic [2:0] {
        KIND_DISTANCE  = 3'd0,
        KIND_SCAN_DONE = 3'd1,
        KIND_BAD_ECHO  = 3'd2,
        KIND_BUSY      = 3'd3,
        KIND_CHECKSUM  = 3'd4
    } t_kind;

    // output unit codes
    typedef enum logic [1:0] {
        UNIT_METRE = 2'd0,
        UNIT_MM    = 2'd1,
        UNIT_INCH  = 2'd2,
        UNIT_FOOT  = 2'd3
    } t_unit;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd4;

    localparam int DIST_CFG_W = 18;
    localparam logic [DIST_CFG_W-1:0] MIN_DIST_RESET = 18'd20;
    localparam logic [DIST_CFG_W-1:0] MAX_DIST_RESET = 18'd5600;

    // configuration register set
    typedef struct packed {
        logic                  scan_mode;
        t_unit                 unit;
        logic                  substitute;
        logic [DIST_CFG_W-1:0] min_distance;
        logic [DIST_CFG_W-1:0] max_distance;
    } t_cfg;

    // control part of a beat between pipeline stages
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_beat_ctl;

    // output distance format
    localparam int DIST_W = 34;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // characters
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_M    = 8'h4D;
    localparam logic [7:0] CHR_D    = 8'h44;
    localparam logic [7:0] CHR_G    = 8'h47;
    localparam logic [7:0] CHR_9    = 8'h39;
    localparam logic [7:0] CHR_B    = 8'h62;
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_P    = 8'h50;
    localparam logic [7:0] CHR_BIAS = 8'h30;

    localparam int DIGIT_W = 6;

    // unit divisors, scaled by ten where the unit is not a whole number of mm
    localparam int DIV_METRE = 1000;
    localparam int DIV_INCH  = 254;
    localparam int DIV_FOOT  = 3048;

    // width of a decoded distance in mm, wide enough for the substitute too
    function automatic int mm_width(input int cpv);
        return (DIGIT_W * cpv > DIST_CFG_W) ? DIGIT_W * cpv : DIST_CFG_W;
    endfunction

endpackage

`default_nettype wire

// ===== design/lsld_parser.sv =====
`default_nettype none

module lsld_parser #(
    parameter int CHARS_PER_VALUE = 3
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lsld_pkg::t_cfg         i_cfg,
    input  wire                    i_rx_valid,
    input  wire  [7:0]             i_rx_byte,
    output logic                   o_rx_ready,
    input  wire                    i_s1_ready,
    output lsld_pkg::t_beat_ctl    o_s1,
    output logic [lsld_pkg::mm_width(CHARS_PER_VALUE)-1:0] o_s1_mm
);
    import lsld_pkg::*;

    localparam int MM_W   = mm_width(CHARS_PER_VALUE);
    localparam int ACC_W  = DIGIT_W * CHARS_PER_VALUE;
    localparam int GV_W   = DIGIT_W * (CHARS_PER_VALUE - 1);
    localparam int CNT_W  = $clog2(CHARS_PER_VALUE);
    localparam logic [1:0] ECHO_LEN   = 2'd2;
    localparam logic [1:0] STATUS_LEN = 2'd3;
    localparam logic [1:0] POS_SAT    = 2'd3;

    typedef enum logic [1:0] {
        LINE_ECHO   = 2'd0,
        LINE_STATUS = 2'd1,
        LINE_STAMP  = 2'd2,
        LINE_DATA   = 2'd3
    } t_line;

    t_line             r_line,   n_line;
    logic [1:0]        r_pos,    n_pos;
    logic [7:0]        r_held,   n_held;
    logic              r_held_v, n_held_v;
    logic [5:0]        r_sum,    n_sum;
    logic              r_miss,   n_miss;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [GV_W-1:0]   r_group,  n_group;
    t_beat_ctl         r_s1;
    logic [MM_W-1:0]   r_s1_mm;

    logic              accept;
    logic              emit;
    t_kind             emit_kind;
    logic [MM_W-1:0]   emit_mm;
    logic              restart;
    logic              clear;
    logic [7:0]        hdr_char;
    logic [1:0]        hdr_limit;
    logic              checksum_ok;
    logic [7:0]        digit_full;
    logic [ACC_W-1:0]  acc;
    logic [CNT_W:0]    cnt_inc;
    logic              group_done;
    logic [MM_W-1:0]   acc_mm;

    assign accept     = i_rx_valid && i_s1_ready;
    assign o_rx_ready = i_s1_ready;

    // expected header character for this line and position
    always_comb begin
        if (r_line == LINE_ECHO) begin
            hdr_limit = ECHO_LEN;
            if (r_pos == 2'd0) begin
                hdr_char = i_cfg.scan_mode ? CHR_M : CHR_G;
            end else begin
                hdr_char = CHR_D;
            end
        end else begin
            hdr_limit = STATUS_LEN;
            if (r_pos < 2'd2) begin
                hdr_char = i_cfg.scan_mode ? CHR_9 : CHR_0;
            end else begin
                hdr_char = i_cfg.scan_mode ? CHR_B : CHR_P;
            end
        end
    end

    // checksum and digit from the held character
    assign checksum_ok = r_held_v && ((8'(r_sum) + CHR_BIAS) == r_held);
    assign digit_full  = r_held - CHR_BIAS;
    assign acc         = {r_group, digit_full[DIGIT_W-1:0]};
    assign cnt_inc     = (CNT_W+1)'(r_count) + (CNT_W+1)'(1);
    assign group_done  = cnt_inc >= (CNT_W+1)'(CHARS_PER_VALUE);

    // substitution of distances under the minimum
    always_comb begin
        acc_mm = MM_W'(acc);
        if (i_cfg.substitute && (acc_mm < MM_W'(i_cfg.min_distance))) begin
            acc_mm = MM_W'(i_cfg.max_distance);
        end
    end

    // next parse state for one character
    always_comb begin
        n_line    = r_line;
        n_pos     = r_pos;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_sum     = r_sum;
        n_miss    = r_miss;
        n_count   = r_count;
        n_group   = r_group;
        emit      = 1'b0;
        emit_kind = KIND_DISTANCE;
        emit_mm   = '0;
        restart   = 1'b0;
        clear     = 1'b0;

        if (i_rx_byte == CHR_LF) begin
            if (r_pos == 2'd0 && !r_held_v) begin
                // empty line closes the scan
                emit      = 1'b1;
                emit_kind = KIND_SCAN_DONE;
                restart   = 1'b1;
            end else begin
                case (r_line)
                    LINE_ECHO: begin
                        if (r_miss || r_pos < ECHO_LEN) begin
                            emit      = 1'b1;
                            emit_kind = KIND_BAD_ECHO;
                            restart   = 1'b1;
                        end else begin
                            n_line = LINE_STATUS;
                            clear  = 1'b1;
                        end
                    end
                    LINE_STATUS: begin
                        if (r_miss || r_pos < STATUS_LEN) begin
                            emit      = 1'b1;
                            emit_kind = KIND_BUSY;
                            restart   = 1'b1;
                        end else begin
                            n_line = LINE_STAMP;
                            clear  = 1'b1;
                        end
                    end
                    default: begin
                        if (!checksum_ok) begin
                            emit      = 1'b1;
                            emit_kind = KIND_CHECKSUM;
                            restart   = 1'b1;
                        end else begin
                            n_line = LINE_DATA;
                            clear  = 1'b1;
                        end
                    end
                endcase
            end
        end else begin
            if (r_line == LINE_ECHO || r_line == LINE_STATUS) begin
                // header compare, later characters ignored
                if (r_pos < hdr_limit && i_rx_byte != hdr_char) begin
                    n_miss = 1'b1;
                end
            end else begin
                // release the held character into sum and group
                if (r_held_v) begin
                    n_sum = r_sum + r_held[5:0];
                    if (r_line == LINE_DATA) begin
                        if (group_done) begin
                            emit    = 1'b1;
                            emit_mm = acc_mm;
                            n_count = '0;
                            n_group = '0;
                        end else begin
                            n_count = cnt_inc[CNT_W-1:0];
                            n_group = acc[GV_W-1:0];
                        end
                    end
                end
                n_held   = i_rx_byte;
                n_held_v = 1'b1;
            end
            if (r_pos != POS_SAT) begin
                n_pos = r_pos + 2'd1;
            end
        end

        if (clear || restart) begin
            n_pos    = '0;
            n_held   = '0;
            n_held_v = 1'b0;
            n_sum    = '0;
            n_miss   = 1'b0;
        end
        if (restart) begin
            n_line  = LINE_ECHO;
            n_count = '0;
            n_group = '0;
        end
    end

    // parse state and first stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= LINE_ECHO;
            r_pos      <= '0;
            r_held     <= '0;
            r_held_v   <= 1'b0;
            r_sum      <= '0;
            r_miss     <= 1'b0;
            r_count    <= '0;
            r_group    <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            if (accept) begin
                r_line   <= n_line;
                r_pos    <= n_pos;
                r_held   <= n_held;
                r_held_v <= n_held_v;
                r_sum    <= n_sum;
                r_miss   <= n_miss;
                r_count  <= n_count;
                r_group  <= n_group;
            end
            if (i_s1_ready) begin
                r_s1.valid <= accept && emit;
            end
        end
        if (i_s1_ready) begin
            r_s1.kind <= emit_kind;
            r_s1_mm   <= emit_mm;
        end
    end

    assign o_s1    = r_s1;
    assign o_s1_mm = r_s1_mm;

endmodule

`default_nettype wire

// ===== design/lsld_scaler.sv =====
`default_nettype none
`include "laser_scan_line_decoder_defines.svh"

module lsld_scaler #(
    parameter int FRACTION_BITS   = 16,
    parameter int CHARS_PER_VALUE = 3
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lsld_pkg::t_unit        i_unit,
    input  lsld_pkg::t_beat_ctl    i_s1,
    input  wire  [lsld_pkg::mm_width(CHARS_PER_VALUE)-1:0] i_s1_mm,
    output logic                   o_s1_ready,
    output logic                   o_res_valid,
    input  wire                    i_res_ready,
    output lsld_pkg::t_kind        o_result_kind,
    output logic [lsld_pkg::DIST_W-1:0] o_distance
);
    import lsld_pkg::*;

    // mm * M + 2^(K-1), shifted right by K, rounds exactly for any mm of MM_W bits
    localparam int MM_W = mm_width(CHARS_PER_VALUE);
    localparam int K    = MM_W + 12;
    localparam int MW   = FRACTION_BITS + K - 4;
    localparam int LW   = (MW + 1) / 2;
    localparam int HW   = MW - LW;
    localparam int SW   = MM_W + MW + 1;
    localparam int QW   = SW - K;
    localparam int XW   = (MM_W + FRACTION_BITS > DIST_W) ? MM_W + FRACTION_BITS : DIST_W;

    localparam logic [127:0] ONE   = 128'd1;
    localparam logic [127:0] SCALE = ONE << (FRACTION_BITS + K);
    localparam logic [127:0] RM = (SCALE + 128'(DIV_METRE - 1)) / 128'(DIV_METRE);
    localparam logic [127:0] RI = (SCALE * 128'd10 + 128'(DIV_INCH - 1)) / 128'(DIV_INCH);
    localparam logic [127:0] RF = (SCALE * 128'd10 + 128'(DIV_FOOT - 1)) / 128'(DIV_FOOT);
    localparam logic [MW-1:0] MUL_METRE = RM[MW-1:0];
    localparam logic [MW-1:0] MUL_INCH  = RI[MW-1:0];
    localparam logic [MW-1:0] MUL_FOOT  = RF[MW-1:0];
    localparam logic [SW-1:0] ROUND_HALF = SW'(ONE << (K - 1));

    logic              en2;
    logic              en3;
    logic [MW-1:0]     mul_sel;
    logic [MM_W+LW-1:0] n_p_lo;
    logic [MM_W+HW-1:0] n_p_hi;

    logic              r_s2_valid;
    t_kind             r_s2_kind;
    logic [MM_W-1:0]   r_s2_mm;
    logic [MM_W+LW-1:0] r_p_lo;
    logic [MM_W+HW-1:0] r_p_hi;

    logic [SW-1:0]     sum;
    logic [QW-1:0]     quot;
    logic [XW-1:0]     dist_x;
    logic              sat;
    logic [DIST_W-1:0] n_dist;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [DIST_W-1:0] r_out_dist;

    // elastic stage enables
    assign en3        = !r_out_valid || i_res_ready;
    assign en2        = !r_s2_valid || en3;
    assign o_s1_ready = !i_s1.valid || en2;

    // reciprocal for the selected unit
    always_comb begin
        case (i_unit)
            UNIT_METRE: mul_sel = MUL_METRE;
            UNIT_INCH:  mul_sel = MUL_INCH;
            UNIT_FOOT:  mul_sel = MUL_FOOT;
            default:    mul_sel = '0;
        endcase
    end

    // two partial products of mm and the reciprocal
    assign n_p_lo = (MM_W+LW)'(i_s1_mm) * (MM_W+LW)'(mul_sel[LW-1:0]);
    assign n_p_hi = (MM_W+HW)'(i_s1_mm) * (MM_W+HW)'(mul_sel[MW-1:LW]);

    // recombine, round, saturate
    assign sum  = (SW'(r_p_hi) << LW) + SW'(r_p_lo) + ROUND_HALF;
    assign quot = sum[SW-1:K];

    always_comb begin
        if (i_unit == UNIT_MM) begin
            dist_x = XW'(r_s2_mm) << FRACTION_BITS;
        end else begin
            dist_x = XW'(quot);
        end
        sat = dist_x > XW'(DIST_MAX);
        if (r_s2_kind != KIND_DISTANCE) begin
            n_dist = '0;
        end else if (sat) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = dist_x[DIST_W-1:0];
        end
    end

    // product stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en2) begin
                r_s2_valid <= i_s1.valid;
            end
            if (en3) begin
                r_out_valid <= r_s2_valid;
            end
        end
        if (en2) begin
            r_s2_kind <= i_s1.kind;
            r_s2_mm   <= i_s1_mm;
            r_p_lo    <= n_p_lo;
            r_p_hi    <= n_p_hi;
        end
        if (en3) begin
            r_out_kind <= r_s2_kind;
            r_out_dist <= n_dist;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_distance    = r_out_dist;

    // a result only appears after the product stage held one
    `LSLD_ASSERT_NOW(a_out_from_s2, i_clk, i_rst_n, $rose(r_out_valid), $past(r_s2_valid),
        "result appeared without a product stage beat")
    // product stage keeps its beat while blocked
    `LSLD_ASSERT_NEXT(a_s2_hold, i_clk, i_rst_n, r_s2_valid && !en2,
        r_s2_valid && $stable(r_p_lo) && $stable(r_p_hi),
        "product stage lost a blocked beat")
    // status results leave with a zero distance
    `LSLD_ASSERT_NEXT(a_status_zero, i_clk, i_rst_n,
        r_s2_valid && en3 && r_s2_kind != KIND_DISTANCE, r_out_dist == '0,
        "status result carries a distance")

endmodule

`default_nettype wire

// ===== design/laser_scan_line_decoder.sv =====
`default_nettype none

// Decodes a rangefinder's serial range answer one received byte per beat and
// takes a byte in every cycle until three results are queued behind a stalled
// output; the byte-side ready follows the result-side ready in the same cycle.
// A byte is parsed in the cycle it is accepted (header compare, checksum,
// digit grouping, substitution of short distances) into a first stage
// register, and the unit conversion runs through a partial-product multiply
// stage and a rounding stage into the output register. Results are distances
// in the chosen unit with FRACTION_BITS fraction bits, saturating at the top
// of the 34-bit field, or status beats (scan complete, bad echo, sensor busy,
// checksum error) with zero distance; after a status beat parsing restarts at
// the echo line. Configuration registers must be written only while the block
// is idle, which the block itself does not enforce; they take effect on the
// next byte.
module laser_scan_line_decoder #(
    parameter int FRACTION_BITS   = 16,
    parameter int CHARS_PER_VALUE = 3
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [lsld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [lsld_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_rx_valid,
    output logic                             o_rx_ready,
    input  wire  [7:0]                       i_rx_byte,
    output logic                             o_res_valid,
    input  wire                              i_res_ready,
    output logic [2:0]                       o_result_kind,
    output logic [lsld_pkg::DIST_W-1:0]      o_distance
);
    import lsld_pkg::*;

    localparam int MM_W = mm_width(CHARS_PER_VALUE);

    t_cfg            r_cfg;
    t_beat_ctl       s1;
    logic [MM_W-1:0] s1_mm;
    logic            s1_ready;
    t_kind           res_kind;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_mode    <= 1'b0;
            r_cfg.unit         <= UNIT_METRE;
            r_cfg.substitute   <= 1'b0;
            r_cfg.min_distance <= MIN_DIST_RESET;
            r_cfg.max_distance <= MAX_DIST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCAN_MODE:  r_cfg.scan_mode    <= i_cfg_data[0];
                REG_UNIT:       r_cfg.unit         <= t_unit'(i_cfg_data[1:0]);
                REG_SUBSTITUTE: r_cfg.substitute   <= i_cfg_data[0];
                REG_MIN_DIST:   r_cfg.min_distance <= i_cfg_data[DIST_CFG_W-1:0];
                REG_MAX_DIST:   r_cfg.max_distance <= i_cfg_data[DIST_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // byte parser
    lsld_parser #(
        .CHARS_PER_VALUE (CHARS_PER_VALUE)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_s1_ready (s1_ready),
        .o_s1       (s1),
        .o_s1_mm    (s1_mm)
    );

    // unit conversion and result register
    lsld_scaler #(
        .FRACTION_BITS   (FRACTION_BITS),
        .CHARS_PER_VALUE (CHARS_PER_VALUE)
    ) u_scaler (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_unit        (r_cfg.unit),
        .i_s1          (s1),
        .i_s1_mm       (s1_mm),
        .o_s1_ready    (s1_ready),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_result_kind (res_kind),
        .o_distance    (o_distance)
    );

    assign o_result_kind = res_kind;

endmodule

`default_nettype wire

// ===== test/tb_laser_scan_line_decoder.sv =====
`timescale 1ns / 1ps

module tb_laser_scan_line_decoder;
    import lsld_pkg::*;

    localparam int FRACTION_BITS   = 16;
    localparam int CHARS_PER_VALUE = 3;
    localparam int PHASES          = 10;
    localparam int PHASE_BYTES     = 105;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT     = 2000000;

    // line numbers within one answer
    localparam logic [1:0] LINE_ECHO   = 2'd0;
    localparam logic [1:0] LINE_STATUS = 2'd1;
    localparam logic [1:0] LINE_STAMP  = 2'd2;
    localparam logic [1:0] LINE_DATA   = 2'd3;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [2:0]        kind;
        logic [DIST_W-1:0] dist_fp;
    } range_result_t;

    // running copy of the decoder and the results it still owes
    class scan_checker;
        logic             scan_mode;
        t_unit            out_unit;
        logic             substitute;
        logic [17:0]      min_mm;
        logic [17:0]      max_mm;
        logic [1:0]       line_idx;
        logic [1:0]       line_pos;
        logic [7:0]       held;
        logic             held_ok;
        logic [5:0]       line_sum;
        logic             hdr_bad;
        int               grp_cnt;
        logic [17:0]      grp_val;
        range_result_t    pending_results[$];
        int               errors;

        function new();
            errors     = 0;
            scan_mode  = 1'b0;
            out_unit   = UNIT_METRE;
            substitute = 1'b0;
            min_mm     = MIN_DIST_RESET;
            max_mm     = MAX_DIST_RESET;
            restart();
        endfunction

        function void clear_line();
            line_pos = 2'd0;
            held     = 8'd0;
            held_ok  = 1'b0;
            line_sum = 6'd0;
            hdr_bad  = 1'b0;
        endfunction

        function void restart();
            line_idx = LINE_ECHO;
            clear_line();
            grp_cnt = 0;
            grp_val = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SCAN_MODE:  scan_mode  = data[0];
                REG_UNIT:       out_unit   = t_unit'(data[1:0]);
                REG_SUBSTITUTE: substitute = data[0];
                REG_MIN_DIST:   min_mm     = data[17:0];
                REG_MAX_DIST:   max_mm     = data[17:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] header_char(logic [1:0] line, logic [1:0] pos);
            if (line == LINE_ECHO)
                return (pos == 2'd0) ? (scan_mode ? CHR_M : CHR_G) : CHR_D;
            if (pos < 2'd2)
                return scan_mode ? CHR_9 : CHR_0;
            return scan_mode ? CHR_B : CHR_P;
        endfunction

        // millimetres to the chosen unit, round half up, saturating
        function logic [DIST_W-1:0] to_unit(logic [23:0] mm);
            logic [63:0] s;
            logic [63:0] r;
            s = 64'(mm) << FRACTION_BITS;
            case (out_unit)
                UNIT_MM:   r = s;
                UNIT_INCH: r = (s * 10 + DIV_INCH / 2) / DIV_INCH;
                UNIT_FOOT: r = (s * 10 + DIV_FOOT / 2) / DIV_FOOT;
                default:   r = (s + DIV_METRE / 2) / DIV_METRE;
            endcase
            if (r > 64'(DIST_MAX))
                r = 64'(DIST_MAX);
            return r[DIST_W-1:0];
        endfunction

        function void post(t_kind k, logic [DIST_W-1:0] d);
            range_result_t res;
            res.kind    = k;
            res.dist_fp = d;
            pending_results.insert(pending_results.size(), res);
        endfunction

        // one accepted character
        function void take_char(logic [7:0] ch);
            logic [5:0]  digit;
            logic [23:0] acc;
            logic [23:0] mm;
            int          limit;
            if (ch == CHR_LF) begin
                // empty line ends the scan anywhere
                if (line_pos == 2'd0 && !held_ok) begin
                    post(KIND_SCAN_DONE, '0);
                    restart();
                    return;
                end
                if (line_idx == LINE_ECHO) begin
                    if (hdr_bad || line_pos < 2'd2) begin
                        post(KIND_BAD_ECHO, '0);
                        restart();
                        return;
                    end
                    line_idx = LINE_STATUS;
                end else if (line_idx == LINE_STATUS) begin
                    if (hdr_bad || line_pos < 2'd3) begin
                        post(KIND_BUSY, '0);
                        restart();
                        return;
                    end
                    line_idx = LINE_STAMP;
                end else begin
                    if (!(held_ok && (8'(line_sum) + CHR_BIAS) == held)) begin
                        post(KIND_CHECKSUM, '0);
                        restart();
                        return;
                    end
                    line_idx = LINE_DATA;
                end
                clear_line();
                return;
            end

            if (line_idx == LINE_ECHO || line_idx == LINE_STATUS) begin
                limit = (line_idx == LINE_ECHO) ? 2 : 3;
                if (line_pos < limit && ch != header_char(line_idx, line_pos))
                    hdr_bad = 1'b1;
            end else begin
                // the held character is not the checksum after all
                if (held_ok) begin
                    line_sum = line_sum + held[5:0];
                    if (line_idx == LINE_DATA) begin
                        digit = 6'(held - CHR_BIAS);
                        acc   = {grp_val, digit};
                        grp_cnt++;
                        if (grp_cnt >= CHARS_PER_VALUE) begin
                            mm = acc;
                            if (substitute && mm < 24'(min_mm))
                                mm = 24'(max_mm);
                            post(KIND_DISTANCE, to_unit(mm));
                            grp_cnt = 0;
                            grp_val = '0;
                        end else begin
                            grp_val = acc[17:0];
                        end
                    end
                end
                held    = ch;
                held_ok = 1'b1;
            end
            if (line_pos != 2'd3)
                line_pos++;
        endfunction

        // one accepted result beat against the oldest owed result
        function void match_result(logic [2:0] kind, logic [DIST_W-1:0] dist_fp);
            range_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none owed: kind %0d distance %0d",
                         $time, kind, dist_fp);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (dist_fp !== want.dist_fp) begin
                $display("%0t: distance expected %0d actual %0d", $time, want.dist_fp,
                         dist_fp);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_rx_valid;
    logic                  o_rx_ready;
    logic [7:0]            i_rx_byte;
    logic                  o_res_valid;
    logic                  i_res_ready;
    logic [2:0]            o_result_kind;
    logic [DIST_W-1:0]     o_distance;

    scan_checker  sb;
    byte_q_t      tx_plan;
    bit           tx_gappy;
    bit           rx_gappy;
    bit           rx_hold_req;
    int unsigned  cycle_count;

    laser_scan_line_decoder #(
        .FRACTION_BITS  (FRACTION_BITS),
        .CHARS_PER_VALUE(CHARS_PER_VALUE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_result_kind(o_result_kind),
        .o_distance   (o_distance)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("laser_scan_line_decoder: mismatch");
        $finish;
    end

    // beat monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready)
                sb.take_char(i_rx_byte);
            if (o_res_valid && i_res_ready)
                sb.match_result(o_result_kind, o_distance);
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // result side: random stalls, one long hold on request
    initial begin : res_sink
        int   run;
        logic ready_next;
        run = 0;
        i_res_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_res_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                i_res_ready <= 1'b1;
            end else if (!rx_gappy) begin
                i_res_ready <= 1'b1;
            end else if (run > 0) begin
                run--;
            end else begin
                ready_next = ($urandom_range(0, 99) < 65);
                run = pick_gap();
                i_res_ready <= ready_next;
            end
        end
    end

    // stimulus building
    function automatic void put_byte(logic [7:0] b);
        tx_plan.insert(tx_plan.size(), b);
    endfunction

    function automatic void put_bytes(byte_q_t q);
        foreach (q[k])
            put_byte(q[k]);
    endfunction

    function automatic byte_q_t str_bytes(string s);
        byte_q_t q;
        for (int k = 0; k < s.len(); k++)
            q.insert(q.size(), 8'(s[k]));
        return q;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHR_LF);
        return b;
    endfunction

    function automatic byte_q_t rand_body(int len, logic payload);
        byte_q_t q;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
                q.insert(q.size(), any_char());
            else if (payload && $urandom_range(0, 3) == 0)
                q.insert(q.size(), CHR_0);
            else
                q.insert(q.size(), 8'(CHR_BIAS + $urandom_range(0, 63)));
        end
        return q;
    endfunction

    // checksummed line, optionally with one checksum bit flipped
    function automatic void add_sum_line(byte_q_t body, logic corrupt);
        logic [5:0] total;
        logic [7:0] ck;
        total = 6'd0;
        foreach (body[k])
            total = total + body[k][5:0];
        put_bytes(body);
        ck = 8'(total) + CHR_BIAS;
        if (corrupt)
            ck = ck ^ (8'd1 << $urandom_range(0, 5));
        put_byte(ck);
        put_byte(CHR_LF);
    endfunction

    // echo or status line, now and then short or with a wrong character
    function automatic void add_header(logic mode, logic is_status);
        logic [7:0] hdr[3];
        int len;
        int r;
        int k;
        len = is_status ? 3 : 2;
        if (is_status) begin
            hdr[0] = mode ? CHR_9 : CHR_0;
            hdr[1] = hdr[0];
            hdr[2] = mode ? CHR_B : CHR_P;
        end else begin
            hdr[0] = mode ? CHR_M : CHR_G;
            hdr[1] = CHR_D;
            hdr[2] = CHR_D;
        end
        r = $urandom_range(0, 39);
        if (r == 0) begin
            len = $urandom_range(1, len - 1);
        end else if (r == 1) begin
            k = $urandom_range(0, len - 1);
            hdr[k] = hdr[k] ^ (8'd1 << $urandom_range(0, 7));
        end
        for (k = 0; k < len; k++)
            put_byte(hdr[k]);
        for (k = $urandom_range(0, 3); k > 0; k--)
            put_byte(any_char());
        put_byte(CHR_LF);
    endfunction

    // one answer: headers, timestamp, payload lines, mostly an empty line
    function automatic void add_scan(logic mode);
        add_header(mode, 1'b0);
        add_header(mode, 1'b1);
        add_sum_line(rand_body($urandom_range(0, 6), 1'b0), $urandom_range(0, 29) == 0);
        for (int k = $urandom_range(1, 4); k > 0; k--)
            add_sum_line(rand_body($urandom_range(0, 10), 1'b1), $urandom_range(0, 29) == 0);
        if ($urandom_range(0, 7) != 0)
            put_byte(CHR_LF);
    endfunction

    // drive the planned bytes, one beat each
    task automatic send_plan();
        int gap;
        for (int k = 0; k < tx_plan.size(); k++) begin
            gap = tx_gappy ? pick_gap() : 0;
            if (k > 0 && gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_rx_valid <= 1'b1;
            i_rx_byte  <= tx_plan[k];
            @(posedge i_clk);
            while (!o_rx_ready)
                @(posedge i_clk);
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b0;
        tx_plan.delete();
    endtask

    // all owed results in, then let the pipeline settle
    task automatic wait_idle();
        while (sb.pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_config(logic mode, t_unit u, logic subst,
                                logic [17:0] lo, logic [17:0] hi);
        write_reg(REG_SCAN_MODE, {17'($urandom), mode});
        write_reg(REG_UNIT, {16'($urandom), u});
        write_reg(REG_SUBSTITUTE, {17'($urandom), subst});
        write_reg(REG_MIN_DIST, lo);
        write_reg(REG_MAX_DIST, hi);
        i_cfg_we <= 1'b0;
    endtask

    // main sequence
    initial begin : main_seq
        logic        mode;
        logic        subst;
        logic [17:0] lo;
        logic [17:0] hi;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = 8'd0;
        tx_gappy    = 1'b1;
        rx_gappy    = 1'b1;
        rx_hold_req = 1'b0;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extra echo char, one-char timestamp, largest and zero
        // distance, empty line, short echo, empty line on the echo line
        put_bytes(str_bytes("GDx\n00P\n"));
        add_sum_line(str_bytes(""), 1'b0);
        add_sum_line(str_bytes("ooo000"), 1'b0);
        put_bytes(str_bytes("\nG\n\n"));
        send_plan();
        wait_idle();

        for (int ph = 1; ph <= PHASES; ph++) begin
            mode  = 1'($urandom_range(0, 1));
            subst = ph[0];
            if (ph == 1) begin
                lo = 18'h3ffff;
                hi = 18'd0;
            end else if (ph == 2) begin
                lo = 18'd0;
                hi = 18'h3ffff;
            end else begin
                lo = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, 3000));
                hi = 18'($urandom);
            end
            apply_config(mode, t_unit'(ph % 4), subst, lo, hi);

            tx_gappy = (ph % 3 != 0);
            rx_gappy = (ph % 4 != 2);
            // long result-side hold while bytes keep coming at full rate
            if (ph == 4) begin
                tx_gappy    = 1'b0;
                rx_gappy    = 1'b1;
                rx_hold_req = 1'b1;
            end

            while (tx_plan.size() < PHASE_BYTES) begin
                if ($urandom_range(0, 9) == 0) begin
                    for (int k = $urandom_range(1, 6); k > 0; k--)
                        put_byte(8'($urandom_range(0, 255)));
                end
                add_scan(($urandom_range(0, 19) == 0) ? !mode : mode);
            end
            send_plan();
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("laser_scan_line_decoder: match");
        else
            $display("laser_scan_line_decoder: mismatch");
        $finish;
    end

endmodule
